[hdl/sgnm_pkg.sv]
`timescale 1ns / 1ps

package sgnm_pkg;

	localparam int MAX_GROUPS = 16;
	localparam int CNT_W      = $clog2(MAX_GROUPS + 1);
	localparam int IDX_W      = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
	localparam int GROUP_W    = 16;
	localparam int RANK_W     = 8;
	localparam int TARGET_W   = RANK_W - 1;
	localparam int CMP_W      = (CNT_W > TARGET_W) ? CNT_W : TARGET_W;

	typedef enum logic [1:0] {
		ACT_CLEAR       = 2'd0,
		ACT_APPEND_LOCAL = 2'd1,
		ACT_APPEND_PEER = 2'd2,
		ACT_QUERY       = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_INVALID = 2'd1,
		STAT_FULL    = 2'd2
	} status_t;

	typedef enum logic [0:0] {
		CFG_PREFER_LOCAL = 1'b0,
		CFG_IS_CLIENT    = 1'b1
	} cfg_index_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WAIT
	} state_t;

endpackage

[hdl/shared_group_nth_match.sv]
`timescale 1ns / 1ps
// channel  | handshake            | payload
// ---------+----------------------+-----------------------------------------
// input    | in_valid / in_stall  | action, group_value, match_rank
// output   | out_valid / out_stall| status, group_or_count
// config   | cfg_we               | cfg_index, cfg_data
//
// clear, append and refused queries are answered without a scan; an accepted
// query scans the preferred list one entry per cycle against the whole other
// list with the input stalled, until the nth match or the end loads the word
// arst_n clears both fill counts, the config bits and all handshake state.
// a word waiting on out_stall is held in the output register; a second one
// is held in a pending register and the input stalls until it moves into the
// output register

module shared_group_nth_match import sgnm_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic                      cfg_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [1:0]                action,
	input  logic [GROUP_W-1:0]        group_value,
	input  logic signed [RANK_W-1:0]  match_rank,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [1:0]                status,
	output logic [GROUP_W-1:0]        group_or_count
);

	state_t state_q, state_d;

	logic                prefer_local_q;
	logic                is_client_q;
	logic [GROUP_W-1:0]  local_q [MAX_GROUPS];
	logic [GROUP_W-1:0]  peer_q [MAX_GROUPS];
	logic [CNT_W-1:0]    local_cnt_q;
	logic [CNT_W-1:0]    peer_cnt_q;

	logic [CNT_W-1:0]    idx_q;
	logic [CNT_W-1:0]    hits_q;
	logic                count_mode_q;
	logic [TARGET_W-1:0] target_q;

	logic                out_valid_q;
	logic [1:0]          out_status_q;
	logic [GROUP_W-1:0]  out_value_q;
	logic [1:0]          pend_status_q;
	logic [GROUP_W-1:0]  pend_value_q;

	logic                accept;
	logic                out_free;
	logic                rank_ok;
	logic                query_go;
	logic [1:0]          imm_status;
	logic [CNT_W-1:0]    pref_cnt;
	logic [CNT_W-1:0]    other_cnt;
	logic [GROUP_W-1:0]  pref_cur;
	logic                other_hit;
	logic [CNT_W-1:0]    hits_inc;
	logic                res_load;
	logic                pend_load;
	logic [1:0]          res_status;
	logic [GROUP_W-1:0]  res_value;
	logic                scan_start;
	logic                idx_step;
	logic                hit_step;

	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign rank_ok  = (match_rank == -8'sd1) || (match_rank > 8'sd0);
	assign query_go = (action == ACT_QUERY) && rank_ok && !is_client_q;

	assign pref_cnt  = prefer_local_q ? local_cnt_q : peer_cnt_q;
	assign other_cnt = prefer_local_q ? peer_cnt_q : local_cnt_q;
	assign pref_cur  = prefer_local_q ? local_q[idx_q[IDX_W-1:0]] : peer_q[idx_q[IDX_W-1:0]];
	assign hits_inc  = hits_q + CNT_W'(1);

	// one preferred entry against every valid entry of the other list
	always_comb begin
		other_hit = 1'b0;
		for (int j = 0; j < MAX_GROUPS; j++) begin
			if (CNT_W'(j) < other_cnt) begin
				if (prefer_local_q) begin
					other_hit = other_hit | (peer_q[j] == pref_cur);
				end else begin
					other_hit = other_hit | (local_q[j] == pref_cur);
				end
			end
		end
	end

	always_comb begin
		unique case (action)
			ACT_CLEAR:        imm_status = STAT_OK;
			ACT_APPEND_LOCAL: imm_status = (local_cnt_q >= CNT_W'(MAX_GROUPS)) ? STAT_FULL : STAT_OK;
			ACT_APPEND_PEER:  imm_status = (peer_cnt_q >= CNT_W'(MAX_GROUPS)) ? STAT_FULL : STAT_OK;
			ACT_QUERY:        imm_status = STAT_INVALID;
			default:          imm_status = STAT_INVALID;
		endcase
	end

	always_comb begin
		state_d    = state_q;
		in_stall   = (state_q != ST_IDLE);
		res_load   = 1'b0;
		pend_load  = 1'b0;
		res_status = STAT_OK;
		res_value  = '0;
		scan_start = 1'b0;
		idx_step   = 1'b0;
		hit_step   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (query_go) begin
						scan_start = 1'b1;
						state_d    = ST_SCAN;
					end else begin
						res_status = imm_status;
						if (out_free) begin
							res_load = 1'b1;
						end else begin
							pend_load = 1'b1;
							state_d   = ST_WAIT;
						end
					end
				end
			end
			ST_SCAN: begin
				priority if (idx_q >= pref_cnt) begin
					if (count_mode_q) begin
						res_status = STAT_OK;
						res_value  = GROUP_W'(hits_q);
					end else begin
						res_status = STAT_INVALID;
					end
					if (out_free) begin
						res_load = 1'b1;
						state_d  = ST_IDLE;
					end else begin
						pend_load = 1'b1;
						state_d   = ST_WAIT;
					end
				end else if (other_hit && !count_mode_q
						&& (CMP_W'(hits_inc) == CMP_W'(target_q))) begin
					res_status = STAT_OK;
					res_value  = pref_cur;
					if (out_free) begin
						res_load = 1'b1;
						state_d  = ST_IDLE;
					end else begin
						pend_load = 1'b1;
						state_d   = ST_WAIT;
					end
				end else begin
					idx_step = 1'b1;
					hit_step = other_hit;
				end
			end
			ST_WAIT: begin
				res_status = pend_status_q;
				res_value  = pend_value_q;
				if (out_free) begin
					res_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefer_local_q <= 1'b0;
			is_client_q    <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PREFER_LOCAL: prefer_local_q <= cfg_data;
				CFG_IS_CLIENT:    is_client_q    <= cfg_data;
				default:          ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_cnt_q <= '0;
			peer_cnt_q  <= '0;
		end else if (accept) begin
			if (action == ACT_CLEAR) begin
				local_cnt_q <= '0;
				peer_cnt_q  <= '0;
			end else if (action == ACT_APPEND_LOCAL && imm_status == STAT_OK) begin
				local_cnt_q <= local_cnt_q + CNT_W'(1);
			end else if (action == ACT_APPEND_PEER && imm_status == STAT_OK) begin
				peer_cnt_q <= peer_cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && action == ACT_APPEND_LOCAL && imm_status == STAT_OK) begin
			local_q[local_cnt_q[IDX_W-1:0]] <= group_value;
		end
		if (accept && action == ACT_APPEND_PEER && imm_status == STAT_OK) begin
			peer_q[peer_cnt_q[IDX_W-1:0]] <= group_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= '0;
			hits_q       <= '0;
			count_mode_q <= 1'b0;
			target_q     <= '0;
		end else if (scan_start) begin
			idx_q        <= '0;
			hits_q       <= '0;
			count_mode_q <= match_rank[RANK_W-1];
			target_q     <= match_rank[TARGET_W-1:0];
		end else begin
			if (idx_step) begin
				idx_q <= idx_q + CNT_W'(1);
			end
			if (hit_step) begin
				hits_q <= hits_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			out_status_q <= res_status;
			out_value_q  <= res_value;
		end
		if (pend_load) begin
			pend_status_q <= res_status;
			pend_value_q  <= res_value;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = out_status_q;
	assign group_or_count = out_value_q;

endmodule

[hdl/sgnm_checker.sv]
`timescale 1ns / 1ps

module sgnm_checker import sgnm_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     out_valid,
	input logic                     out_stall,
	input logic [1:0]               status,
	input logic [GROUP_W-1:0]       group_or_count
);

	// stalled word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(group_or_count))
		else $error("output word changed while stalled");

	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STAT_FULL |-> group_or_count == '0)
		else $error("list full word carries nonzero value");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STAT_INVALID |-> group_or_count == '0)
		else $error("invalid word carries nonzero value");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == STAT_OK || status == STAT_INVALID || status == STAT_FULL))
		else $error("undefined status code");

endmodule

bind shared_group_nth_match sgnm_checker u_sgnm_checker (.*);

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
	import sgnm_pkg::*;

	localparam int RAND_ITEMS  = 980;
	localparam int HOLD_CYCLES = 300;
	localparam int LIMIT       = 400000;

	typedef struct packed {
		status_t           st;
		logic [GROUP_W-1:0] val;
	} answer_t;

	typedef struct {
		bit                       is_cfg;
		cfg_index_t               ridx;
		bit                       rval;
		action_t                  act;
		logic [GROUP_W-1:0]       gv;
		logic signed [RANK_W-1:0] rank;
		int                       reps;
		bit                       typed;
		status_t                  st;
		logic [GROUP_W-1:0]       val;
	} row_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_we = 1'b0;
	logic                      cfg_index = 1'b0;
	logic                      cfg_data = 1'b0;
	logic                      in_valid = 1'b0;
	logic                      in_stall;
	logic [1:0]                action = 2'd0;
	logic [GROUP_W-1:0]        group_value = '0;
	logic signed [RANK_W-1:0]  match_rank = '0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic [1:0]                status;
	logic [GROUP_W-1:0]        group_or_count;

	shared_group_nth_match u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.group_value(group_value),
		.match_rank(match_rank),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.group_or_count(group_or_count)
	);

	// shadow of the block
	logic [GROUP_W-1:0] loc_ids [MAX_GROUPS];
	logic [GROUP_W-1:0] peer_ids[MAX_GROUPS];
	int                 loc_n = 0;
	int                 peer_n = 0;
	bit                 pref_local = 1'b0;
	bit                 client_role = 1'b0;

	answer_t answers_due[$];
	row_t    dir_rows[$];
	answer_t got_front;
	int      errors = 0;
	int      cycles = 0;
	int      sent = 0;
	bit      calm = 1'b0;
	bit      hold_go = 1'b0;

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic answer_t apply_to_lists(action_t act, logic [GROUP_W-1:0] gv,
			logic signed [RANK_W-1:0] rank);
		answer_t            a;
		logic [GROUP_W-1:0] pa[MAX_GROUPS];
		logic [GROUP_W-1:0] sa[MAX_GROUPS];
		int                 pn;
		int                 sn;
		int                 hits;
		bit                 found;
		bit                 seen;
		a.st  = STAT_OK;
		a.val = '0;
		case (act)
			ACT_CLEAR: begin
				for (int i = 0; i < MAX_GROUPS; i++) begin
					loc_ids[i]  = '0;
					peer_ids[i] = '0;
				end
				loc_n  = 0;
				peer_n = 0;
			end
			ACT_APPEND_LOCAL: begin
				if (loc_n >= MAX_GROUPS) a.st = STAT_FULL;
				else begin
					loc_ids[loc_n] = gv;
					loc_n++;
				end
			end
			ACT_APPEND_PEER: begin
				if (peer_n >= MAX_GROUPS) a.st = STAT_FULL;
				else begin
					peer_ids[peer_n] = gv;
					peer_n++;
				end
			end
			default: begin
				if (rank < -1 || rank == 0 || client_role) a.st = STAT_INVALID;
				else begin
					if (pref_local) begin
						pa = loc_ids;
						sa = peer_ids;
						pn = loc_n;
						sn = peer_n;
					end else begin
						pa = peer_ids;
						sa = loc_ids;
						pn = peer_n;
						sn = loc_n;
					end
					hits  = 0;
					found = 1'b0;
					for (int i = 0; i < pn && !found; i++) begin
						seen = 1'b0;
						for (int j = 0; j < sn && !seen; j++) begin
							if (pa[i] == sa[j]) begin
								seen = 1'b1;
								hits++;
								if (rank > 0 && hits == rank) begin
									found = 1'b1;
									a.val = pa[i];
								end
							end
						end
					end
					if (rank == -1) a.val = GROUP_W'(hits);
					else if (!found) begin
						a.st  = STAT_INVALID;
						a.val = '0;
					end
				end
			end
		endcase
		return a;
	endfunction

	function automatic logic [GROUP_W-1:0] pick_id(logic [GROUP_W-1:0] base);
		if ($urandom_range(0, 9) == 0) return GROUP_W'($urandom);
		return base ^ GROUP_W'($urandom_range(0, 7));
	endfunction

	function automatic logic signed [RANK_W-1:0] rand_rank();
		case ($urandom_range(0, 9))
			0, 1, 2: return -8'sd1;
			8:       return RANK_W'($urandom);
			9:       return RANK_W'(-$urandom_range(0, 4));
			default: return RANK_W'($urandom_range(1, 18));
		endcase
	endfunction

	task automatic flag_mismatch(string what, int got, int want);
		errors++;
		$display("mismatch at cycle %0d: %s got %0d want %0d", cycles, what, got, want);
	endtask

	task automatic row_word(action_t act, logic [GROUP_W-1:0] gv,
			logic signed [RANK_W-1:0] rank, int reps, bit typed, status_t st,
			logic [GROUP_W-1:0] val);
		row_t r;
		r.is_cfg = 1'b0;
		r.ridx   = CFG_PREFER_LOCAL;
		r.rval   = 1'b0;
		r.act    = act;
		r.gv     = gv;
		r.rank   = rank;
		r.reps   = reps;
		r.typed  = typed;
		r.st     = st;
		r.val    = val;
		dir_rows.push_back(r);
	endtask

	task automatic row_reg(cfg_index_t idx, bit val);
		row_t r;
		r.is_cfg = 1'b1;
		r.ridx   = idx;
		r.rval   = val;
		r.act    = ACT_CLEAR;
		r.gv     = '0;
		r.rank   = '0;
		r.reps   = 0;
		r.typed  = 1'b0;
		r.st     = STAT_OK;
		r.val    = '0;
		dir_rows.push_back(r);
	endtask

	task automatic send_word(action_t act, logic [GROUP_W-1:0] gv,
			logic signed [RANK_W-1:0] rank, bit typed, status_t st,
			logic [GROUP_W-1:0] val);
		int      gap;
		answer_t a;
		gap = calm ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		action      <= act;
		group_value <= gv;
		match_rank  <= rank;
		do @(posedge clk); while (in_stall);
		a = apply_to_lists(act, gv, rank);
		if (typed) begin
			a.st  = st;
			a.val = val;
		end
		answers_due.push_back(a);
		sent++;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (answers_due.size() != 0);
	endtask

	task automatic write_reg(cfg_index_t idx, bit val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_PREFER_LOCAL) pref_local = val;
		else client_role = val;
		@(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (answers_due.size() == 0) flag_mismatch("unexpected word", status, 0);
			else begin
				got_front = answers_due.pop_front();
				if (status !== got_front.st) flag_mismatch("status", status, got_front.st);
				if (group_or_count !== got_front.val)
					flag_mismatch("group_or_count", group_or_count, got_front.val);
			end
		end
	end

	// receiver
	initial begin : sink
		int hold;
		@(posedge arst_n);
		forever begin
			if (hold_go) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_go = 1'b0;
			end
			hold = calm ? 0 : $urandom_range(0, 8);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin : stim
		int                 seq_no;
		int                 n_loc;
		int                 n_peer;
		int                 nq;
		logic [GROUP_W-1:0] base;
		for (int i = 0; i < MAX_GROUPS; i++) begin
			loc_ids[i]  = '0;
			peer_ids[i] = '0;
		end

		row_word(ACT_QUERY, 16'h0000, -8'sd1, 1, 1, STAT_OK, 16'd0);
		row_word(ACT_QUERY, 16'hFFFF, 8'sd0, 1, 1, STAT_INVALID, 16'd0);
		row_word(ACT_QUERY, 16'h0000, -8'sd128, 1, 1, STAT_INVALID, 16'd0);
		row_word(ACT_QUERY, 16'h0000, -8'sd2, 1, 1, STAT_INVALID, 16'd0);
		row_word(ACT_QUERY, 16'h0000, 8'sd1, 1, 1, STAT_INVALID, 16'd0);
		row_word(ACT_APPEND_LOCAL, 16'hFFFF, 8'sd127, 1, 1, STAT_OK, 16'd0);
		row_word(ACT_APPEND_PEER, 16'hFFFF, -8'sd128, 1, 1, STAT_OK, 16'd0);
		row_word(ACT_APPEND_LOCAL, 16'h0000, 8'sd0, 2, 1, STAT_OK, 16'd0);
		row_word(ACT_APPEND_PEER, 16'h0000, 8'sd0, 1, 1, STAT_OK, 16'd0);
		row_word(ACT_APPEND_PEER, 16'h1234, 8'sd0, 1, 1, STAT_OK, 16'd0);
		row_word(ACT_QUERY, 16'h0000, -8'sd1, 1, 1, STAT_OK, 16'd2);
		row_word(ACT_QUERY, 16'h0000, 8'sd127, 1, 1, STAT_INVALID, 16'd0);
		row_word(ACT_QUERY, 16'h0000, 8'sd1, 1, 1, STAT_OK, 16'hFFFF);
		row_word(ACT_QUERY, 16'h0000, 8'sd2, 1, 0, STAT_OK, 16'd0);
		row_word(ACT_QUERY, 16'h0000, 8'sd3, 1, 1, STAT_INVALID, 16'd0);
		row_reg(CFG_PREFER_LOCAL, 1'b1);
		// duplicates in the preferred list count each time
		row_word(ACT_QUERY, 16'h0000, -8'sd1, 1, 1, STAT_OK, 16'd3);
		row_word(ACT_QUERY, 16'h0000, 8'sd3, 1, 0, STAT_OK, 16'd0);
		row_reg(CFG_IS_CLIENT, 1'b1);
		row_word(ACT_QUERY, 16'h0000, -8'sd1, 1, 1, STAT_INVALID, 16'd0);
		row_word(ACT_QUERY, 16'h0000, 8'sd1, 1, 1, STAT_INVALID, 16'd0);
		row_word(ACT_APPEND_LOCAL, 16'hA5A5, 8'sd1, 1, 1, STAT_OK, 16'd0);
		row_reg(CFG_IS_CLIENT, 1'b0);
		row_word(ACT_CLEAR, 16'hFFFF, 8'sd127, 1, 1, STAT_OK, 16'd0);
		row_word(ACT_APPEND_LOCAL, 16'h5A5A, 8'sd1, MAX_GROUPS, 1, STAT_OK, 16'd0);
		row_word(ACT_APPEND_LOCAL, 16'h0001, 8'sd1, 1, 1, STAT_FULL, 16'd0);
		row_word(ACT_APPEND_PEER, 16'h5A5A, 8'sd1, MAX_GROUPS, 1, STAT_OK, 16'd0);
		row_word(ACT_APPEND_PEER, 16'h0001, 8'sd1, 1, 1, STAT_FULL, 16'd0);
		row_word(ACT_QUERY, 16'h0000, -8'sd1, 1, 1, STAT_OK, 16'(MAX_GROUPS));
		row_word(ACT_QUERY, 16'h0000, 8'(MAX_GROUPS), 1, 1, STAT_OK, 16'h5A5A);
		row_word(ACT_QUERY, 16'h0000, 8'(MAX_GROUPS + 1), 1, 1, STAT_INVALID, 16'd0);
		row_reg(CFG_PREFER_LOCAL, 1'b0);
		row_word(ACT_QUERY, 16'h0000, -8'sd1, 1, 0, STAT_OK, 16'd0);
		row_word(ACT_CLEAR, 16'h0000, 8'sd0, 1, 1, STAT_OK, 16'd0);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[r]) begin
			if (dir_rows[r].is_cfg) begin
				drain_results();
				write_reg(dir_rows[r].ridx, dir_rows[r].rval);
			end else begin
				repeat (dir_rows[r].reps)
					send_word(dir_rows[r].act, dir_rows[r].gv, dir_rows[r].rank,
						dir_rows[r].typed, dir_rows[r].st, dir_rows[r].val);
			end
		end

		sent   = 0;
		seq_no = 0;
		while (sent < RAND_ITEMS) begin
			calm = ($urandom_range(0, 4) == 0);
			if (seq_no == 3) begin
				// long receiver hold while words keep coming
				calm    = 1'b1;
				hold_go = 1'b1;
			end
			if (seq_no == 0 || $urandom_range(0, 2) == 0) begin
				drain_results();
				write_reg(CFG_PREFER_LOCAL, $urandom_range(0, 1));
				write_reg(CFG_IS_CLIENT, $urandom_range(0, 5) == 0);
			end
			base = GROUP_W'($urandom);
			if ($urandom_range(0, 9) != 0)
				send_word(ACT_CLEAR, GROUP_W'($urandom), RANK_W'($urandom), 0, STAT_OK, '0);
			n_loc  = ($urandom_range(0, 5) == 0) ? $urandom_range(14, 19) : $urandom_range(0, 9);
			n_peer = ($urandom_range(0, 5) == 0) ? $urandom_range(14, 19) : $urandom_range(0, 9);
			while (n_loc + n_peer > 0) begin
				if (n_peer == 0 || (n_loc > 0 && $urandom_range(0, 1) == 1)) begin
					send_word(ACT_APPEND_LOCAL, pick_id(base), rand_rank(), 0, STAT_OK, '0);
					n_loc--;
				end else begin
					send_word(ACT_APPEND_PEER, pick_id(base), rand_rank(), 0, STAT_OK, '0);
					n_peer--;
				end
				if ($urandom_range(0, 15) == 0)
					send_word(action_t'($urandom_range(0, 3)), GROUP_W'($urandom),
						RANK_W'($urandom), 0, STAT_OK, '0);
			end
			nq = $urandom_range(1, 6);
			repeat (nq) begin
				send_word(ACT_QUERY, GROUP_W'($urandom), rand_rank(), 0, STAT_OK, '0);
				if ($urandom_range(0, 15) == 0)
					send_word(action_t'($urandom_range(0, 3)), GROUP_W'($urandom),
						RANK_W'($urandom), 0, STAT_OK, '0);
			end
			seq_no++;
		end

		drain_results();
		repeat (MAX_GROUPS + 4) @(posedge clk);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

[shared_group_nth_match.f]
hdl/sgnm_pkg.sv
hdl/shared_group_nth_match.sv
hdl/sgnm_checker.sv
tb/tb.sv
